[rtl/sequence_reorder_buffer_defines.svh]
// assertion macros used by the reorder buffer back end
`ifndef SEQUENCE_REORDER_BUFFER_DEFINES_SVH
`define SEQUENCE_REORDER_BUFFER_DEFINES_SVH

// condition that holds at every clock edge out of reset
`define SRB_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence that holds in the cycle after the antecedent
`define SRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/srb_pkg.sv]
// shared types and constants for the sequence reorder buffer
package srb_pkg;

  localparam int SEQ_W         = 32;
  localparam int HANDLE_PORT_W = 16;

  // command codes produced by the front end
  typedef enum logic [2:0] {
    CMD_PASS      = 3'd0,
    CMD_DUPLICATE = 3'd1,
    CMD_OVERFLOW  = 3'd2,
    CMD_HOLD      = 3'd3,
    CMD_DELIVER   = 3'd4
  } cmd_kind_t;

  // one classified item
  typedef struct packed {
    cmd_kind_t                kind;
    logic [SEQ_W-1:0]         seq;
    logic [HANDLE_PORT_W-1:0] handle;
  } cmd_t;

  // back end state seen by the front end
  typedef struct packed {
    logic             drain_busy;
    logic [SEQ_W-1:0] next_expected;
  } back_status_t;

endpackage

[rtl/srb_front.sv]
// front end: config register, item accept and classification into a command register
module srb_front #(
  parameter int WINDOW      = 64,
  parameter int HANDLE_BITS = 16,
  localparam int IDXW       = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic                               cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [srb_pkg::SEQ_W-1:0]          in_sequence_number,
  input  logic [srb_pkg::HANDLE_PORT_W-1:0]  in_packet_handle,
  input  srb_pkg::back_status_t              status,
  input  logic [IDXW-1:0]                    exp_idx,
  output logic                               cmd_valid,
  input  logic                               cmd_ready,
  output srb_pkg::cmd_t                      cmd,
  output logic [IDXW-1:0]                    cmd_idx
);
  import srb_pkg::*;

  localparam int HW = (HANDLE_BITS < HANDLE_PORT_W) ? HANDLE_BITS : HANDLE_PORT_W;
  localparam logic [IDXW:0]    WIN_SUM = (IDXW+1)'(WINDOW);
  localparam logic [SEQ_W-1:0] WIN_SEQ = SEQ_W'(WINDOW);

  logic             reorder_en_r;
  logic             cmd_valid_r, cmd_valid_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [IDXW-1:0]  cmd_idx_r, cmd_idx_nxt;
  logic             accept;
  logic [SEQ_W-1:0] seq_gap;
  logic [HW-1:0]    handle_m;
  logic [IDXW:0]    idx_sum;

  // reorder enable register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reorder_en_r <= 1'b1;
    end else if (cfg_wr_en) begin
      reorder_en_r <= cfg_wr_data;
    end
  end

  // take an item only while the command register is empty and the expected number is settled
  assign in_ready = !cmd_valid_r && !status.drain_busy;
  assign accept   = in_valid && in_ready;

  // classify against the expected number, or pass through while reordering is off
  always_comb begin
    seq_gap  = in_sequence_number - status.next_expected;
    handle_m = in_packet_handle[HW-1:0];
    idx_sum  = {1'b0, exp_idx} + {1'b0, seq_gap[IDXW-1:0]};
    if (idx_sum >= WIN_SUM) begin
      idx_sum = idx_sum - WIN_SUM;
    end

    cmd_nxt.seq    = in_sequence_number;
    cmd_nxt.handle = HANDLE_PORT_W'(handle_m);
    if (!reorder_en_r) begin
      cmd_nxt.kind = CMD_PASS;
    end else if (in_sequence_number < status.next_expected) begin
      cmd_nxt.kind = CMD_DUPLICATE;
    end else if (seq_gap == '0) begin
      cmd_nxt.kind = CMD_DELIVER;
    end else if (seq_gap >= WIN_SEQ) begin
      cmd_nxt.kind = CMD_OVERFLOW;
    end else begin
      cmd_nxt.kind = CMD_HOLD;
    end
    cmd_idx_nxt = idx_sum[IDXW-1:0];

    cmd_valid_nxt = cmd_valid_r && !cmd_ready;
    if (accept) begin
      cmd_valid_nxt = 1'b1;
    end
  end

  // command register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
    end else begin
      cmd_valid_r <= cmd_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r     <= cmd_nxt;
      cmd_idx_r <= cmd_idx_nxt;
    end
  end

  assign cmd_valid = cmd_valid_r;
  assign cmd       = cmd_r;
  assign cmd_idx   = cmd_idx_r;

endmodule

[rtl/srb_back.sv]
// back end: slot store, expected counter, drain sequencer and output register
`include "sequence_reorder_buffer_defines.svh"

module srb_back #(
  parameter int WINDOW      = 64,
  parameter int HANDLE_BITS = 16,
  localparam int IDXW       = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cmd_valid,
  output logic                               cmd_ready,
  input  srb_pkg::cmd_t                      cmd,
  input  logic [IDXW-1:0]                    cmd_idx,
  output srb_pkg::back_status_t              status,
  output logic [IDXW-1:0]                    exp_idx,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [srb_pkg::HANDLE_PORT_W-1:0]  out_handle,
  output logic [srb_pkg::SEQ_W-1:0]          out_sequence,
  output logic [1:0]                         out_disposition,
  output logic                               out_last_of_run
);
  import srb_pkg::*;

  localparam int HW = (HANDLE_BITS < HANDLE_PORT_W) ? HANDLE_BITS : HANDLE_PORT_W;
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(WINDOW - 1);
  localparam logic [IDXW-1:0] CNT_MAX  = IDXW'(WINDOW - 1);

  localparam logic [1:0] DISP_DELIVERED = 2'd0;
  localparam logic [1:0] DISP_DUPLICATE = 2'd1;
  localparam logic [1:0] DISP_OVERFLOW  = 2'd2;
  localparam logic [1:0] DISP_REPLACED  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_REPL  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t                   state_r, state_nxt;
  logic [SEQ_W-1:0]         ne_r, ne_nxt;
  logic [IDXW-1:0]          eidx_r, eidx_nxt;
  logic [WINDOW-1:0]        slot_valid_r, slot_valid_nxt;
  logic                     flush_r, flush_nxt;
  logic [IDXW-1:0]          cnt_r, cnt_nxt;
  logic [SEQ_W-1:0]         repl_seq_r, repl_seq_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [HANDLE_PORT_W-1:0] out_handle_r, out_handle_nxt;
  logic [SEQ_W-1:0]         out_seq_r, out_seq_nxt;
  logic [1:0]               out_disp_r, out_disp_nxt;
  logic                     out_last_r, out_last_nxt;

  logic [HW-1:0]            slot_mem [WINDOW];
  logic [HW-1:0]            rd_data_r;
  logic                     rd_en, wr_en;
  logic [IDXW-1:0]          rd_addr, wr_addr;
  logic [HW-1:0]            wr_data;

  logic                     out_free, pop, out_load;
  logic [IDXW-1:0]          nidx;
  logic                     nvalid, more_ok;

  assign out_free  = !out_valid_r || out_ready;
  assign cmd_ready = (state_r == ST_IDLE) && out_free;
  assign pop       = cmd_valid && cmd_ready;

  // slot index of the number after the expected one, with the 32-bit wrap
  always_comb begin
    if ((ne_r == '1) || (eidx_r == LAST_IDX)) begin
      nidx = '0;
    end else begin
      nidx = eidx_r + 1'b1;
    end
    nvalid  = slot_valid_r[nidx];
    more_ok = !flush_r && nvalid && (cnt_r != CNT_MAX);
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    ne_nxt         = ne_r;
    eidx_nxt       = eidx_r;
    slot_valid_nxt = slot_valid_r;
    flush_nxt      = flush_r;
    cnt_nxt        = cnt_r;
    repl_seq_nxt   = repl_seq_r;
    out_load       = 1'b0;
    out_handle_nxt = out_handle_r;
    out_seq_nxt    = out_seq_r;
    out_disp_nxt   = out_disp_r;
    out_last_nxt   = out_last_r;
    rd_en          = 1'b0;
    rd_addr        = nidx;
    wr_en          = 1'b0;
    wr_addr        = cmd_idx;
    wr_data        = cmd.handle[HW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (pop) begin
          unique case (cmd.kind)
            CMD_DUPLICATE: begin
              out_load       = 1'b1;
              out_handle_nxt = cmd.handle;
              out_seq_nxt    = cmd.seq;
              out_disp_nxt   = DISP_DUPLICATE;
              out_last_nxt   = 1'b1;
            end
            CMD_OVERFLOW: begin
              out_load       = 1'b1;
              out_handle_nxt = cmd.handle;
              out_seq_nxt    = cmd.seq;
              out_disp_nxt   = DISP_OVERFLOW;
              out_last_nxt   = 1'b1;
            end
            CMD_HOLD: begin
              // read the old handle and write the new one in the same cycle
              rd_en                   = 1'b1;
              rd_addr                 = cmd_idx;
              wr_en                   = 1'b1;
              slot_valid_nxt[cmd_idx] = 1'b1;
              repl_seq_nxt            = cmd.seq;
              if (slot_valid_r[cmd_idx]) begin
                state_nxt = ST_REPL;
              end
            end
            CMD_DELIVER, CMD_PASS: begin
              out_load       = 1'b1;
              out_handle_nxt = cmd.handle;
              out_seq_nxt    = cmd.seq;
              out_disp_nxt   = DISP_DELIVERED;
              out_last_nxt   = !nvalid;
              ne_nxt         = ne_r + 1'b1;
              eidx_nxt       = nidx;
              flush_nxt      = (cmd.kind == CMD_PASS);
              cnt_nxt        = IDXW'(1);
              if (nvalid) begin
                rd_en                = 1'b1;
                slot_valid_nxt[nidx] = 1'b0;
                state_nxt            = ST_DRAIN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_REPL: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_handle_nxt = HANDLE_PORT_W'(rd_data_r);
          out_seq_nxt    = repl_seq_r;
          out_disp_nxt   = DISP_REPLACED;
          out_last_nxt   = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_DRAIN: begin
        // emit the slot read earlier, fetch the next one if more_ok holds
        if (out_free) begin
          out_load       = 1'b1;
          out_handle_nxt = HANDLE_PORT_W'(rd_data_r);
          out_seq_nxt    = ne_r;
          out_disp_nxt   = flush_r ? DISP_DUPLICATE : DISP_DELIVERED;
          out_last_nxt   = !more_ok;
          if (!flush_r) begin
            ne_nxt   = ne_r + 1'b1;
            eidx_nxt = nidx;
          end
          if (more_ok) begin
            rd_en                = 1'b1;
            slot_valid_nxt[nidx] = 1'b0;
            cnt_nxt              = cnt_r + 1'b1;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r && !out_ready;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ne_r         <= '0;
      eidx_r       <= '0;
      slot_valid_r <= '0;
      flush_r      <= 1'b0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ne_r         <= ne_nxt;
      eidx_r       <= eidx_nxt;
      slot_valid_r <= slot_valid_nxt;
      flush_r      <= flush_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    repl_seq_r   <= repl_seq_nxt;
    out_handle_r <= out_handle_nxt;
    out_seq_r    <= out_seq_nxt;
    out_disp_r   <= out_disp_nxt;
    out_last_r   <= out_last_nxt;
  end

  // handle store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= slot_mem[rd_addr];
    end
  end

  assign status.drain_busy    = (state_r == ST_DRAIN);
  assign status.next_expected = ne_r;
  assign exp_idx              = eidx_r;

  assign out_valid       = out_valid_r;
  assign out_handle      = out_handle_r;
  assign out_sequence    = out_seq_r;
  assign out_disposition = out_disp_r;
  assign out_last_of_run = out_last_r;

  // checks
  `SRB_ASSERT_ALWAYS(a_expected_slot_empty, !slot_valid_r[eidx_r], "expected slot is held")
  `SRB_ASSERT_NEXT(a_repl_keeps_expected, state_r == ST_REPL, $stable(ne_r), "expected moved")
  `SRB_ASSERT_ALWAYS(a_open_run_drains, !(out_valid_r && !out_last_r) || (state_r == ST_DRAIN), "run left open")

endmodule

[rtl/sequence_reorder_buffer.sv]
// top level of the sequence number reorder buffer
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_sequence_number, in_packet_handle
//   out      output     out_valid / out_ready  out_handle, out_sequence,
//                                              out_disposition, out_last_of_run
//   cfg      input      cfg_wr_en              cfg_wr_data (reorder enable)
//
// when the output is free, an item is classified into the command register and
// the back end then takes it from there into the output register
// a delivery that releases held slots emits them in a drain, one handle store read each
// new items wait while a drain runs, since the expected number is still moving
// reset clears the slot valid flags at once, there is no clearing pass
// out_ready low stalls the back end, the front end keeps one classified item
module sequence_reorder_buffer #(
  parameter int WINDOW      = 64,
  parameter int HANDLE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic                               cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [srb_pkg::SEQ_W-1:0]          in_sequence_number,
  input  logic [srb_pkg::HANDLE_PORT_W-1:0]  in_packet_handle,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [srb_pkg::HANDLE_PORT_W-1:0]  out_handle,
  output logic [srb_pkg::SEQ_W-1:0]          out_sequence,
  output logic [1:0]                         out_disposition,
  output logic                               out_last_of_run
);
  import srb_pkg::*;

  localparam int IDXW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  back_status_t    status;
  logic [IDXW-1:0] exp_idx;
  logic            cmd_valid;
  logic            cmd_ready;
  cmd_t            cmd;
  logic [IDXW-1:0] cmd_idx;

  // accept and classify
  srb_front #(
    .WINDOW      (WINDOW),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_sequence_number (in_sequence_number),
    .in_packet_handle   (in_packet_handle),
    .status             (status),
    .exp_idx            (exp_idx),
    .cmd_valid          (cmd_valid),
    .cmd_ready          (cmd_ready),
    .cmd                (cmd),
    .cmd_idx            (cmd_idx)
  );

  // hold, drain and emit
  srb_back #(
    .WINDOW      (WINDOW),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd_valid),
    .cmd_ready       (cmd_ready),
    .cmd             (cmd),
    .cmd_idx         (cmd_idx),
    .status          (status),
    .exp_idx         (exp_idx),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_handle      (out_handle),
    .out_sequence    (out_sequence),
    .out_disposition (out_disposition),
    .out_last_of_run (out_last_of_run)
  );

endmodule
